// ===== rtl/bur_pkg.sv =====
// Shared types and constants of the bilinear RGBA upscaler.
package bur_pkg;

  localparam int unsigned DEF_MAX_SRC_WIDTH  = 128;
  localparam int unsigned DEF_MAX_SRC_HEIGHT = 128;
  localparam int unsigned DEF_FRAC_BITS      = 8;

  localparam int unsigned POS_W      = 12;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned PIX_W      = 4 * CHAN_W;
  localparam int unsigned SRC_REG_W  = 8;
  localparam int unsigned DST_REG_W  = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned DST_MAX    = 4096;

  localparam logic [SRC_REG_W-1:0] SRC_WIDTH_RST  = SRC_REG_W'(128);
  localparam logic [SRC_REG_W-1:0] SRC_HEIGHT_RST = SRC_REG_W'(128);
  localparam logic [DST_REG_W-1:0] DST_WIDTH_RST  = DST_REG_W'(256);
  localparam logic [DST_REG_W-1:0] DST_HEIGHT_RST = DST_REG_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH,
    CFG_SRC_HEIGHT,
    CFG_DST_WIDTH,
    CFG_DST_HEIGHT
  } cfg_reg_e;

  typedef enum logic {
    FUNC_WRITE   = 1'b0,
    FUNC_REQUEST = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_DIV_X,
    ST_MUL_Y,
    ST_DIV_Y,
    ST_RD,
    ST_MAC,
    ST_DONE
  } bur_state_e;

  typedef struct packed {
    logic              func;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;
    logic [CHAN_W-1:0] in_alpha;
  } bur_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_alpha;
  } bur_out_t;

endpackage

// ===== rtl/bur_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module bur_div #(
  parameter int unsigned DEN_W = 12,
  parameter int unsigned QUO_W = 15,
  localparam int unsigned NUM_W = DEN_W + QUO_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [QUO_W-1:0] quo_o
);

  localparam int unsigned CW = $clog2(QUO_W + 1);

  logic             busy_q;
  logic [CW-1:0]    cnt_q;
  logic [DEN_W-1:0] rem_q;
  logic [QUO_W-1:0] quo_q;
  logic [DEN_W-1:0] den_q;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           ge;

  // caller guarantees num < den * 2^QUO_W, so the top part starts below den
  assign trial = {rem_q, quo_q[QUO_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(QUO_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // numerator low bits shift out as quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[NUM_W-1:QUO_W];
      quo_q <= num_i[QUO_W-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/bilinear_upscale_rgba_top.sv =====
// Bilinear RGBA upscaler with corner-aligned mapping and on-chip frame store.
//
// Input channel (in_valid_i/in_ready_o/in_data_i): func = write stores one source
// pixel at (pos_x, pos_y); writes outside the store are dropped. A write is taken
// in idle and the block is ready again in the next cycle.
// func = request names a destination pixel; one RGBA result comes out on the
// output channel (out_valid_o/out_ready_i/out_data_o), none for a write.
// A request runs through a multiply, a bit-serial divide for x and one for y
// (skipped for y on the last row), then up to four frame store reads; each
// neighbour read passes a read state and an accumulate state, a skipped
// neighbour the read state only. The shared divider and the single frame store
// port make these steps run in sequence. in_ready_o is low for the whole
// request and returns as the result is loaded.
// Configuration transfers (cfg_valid_i/cfg_index_i/cfg_data_i) are always taken.
// The result sits in an output register: a stalled receiver does not block new
// writes, only a second result waits in the final state until the first is taken.
// Reset restores the default register values and empties the output; the frame
// store contents stay undefined until written.
module bilinear_upscale_rgba_top #(
  parameter int unsigned MAX_SRC_WIDTH  = bur_pkg::DEF_MAX_SRC_WIDTH,
  parameter int unsigned MAX_SRC_HEIGHT = bur_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int unsigned FRAC_BITS      = bur_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  bur_pkg::bur_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output bur_pkg::bur_out_t                 out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bur_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bur_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned XW     = $clog2(MAX_SRC_WIDTH);
  localparam int unsigned YW     = $clog2(MAX_SRC_HEIGHT);
  localparam int unsigned MW     = (XW > YW) ? XW : YW;
  localparam int unsigned QW     = MW + FRAC_BITS;
  localparam int unsigned DEN_W  = bur_pkg::POS_W;
  localparam int unsigned NUM_W  = DEN_W + QW;
  localparam int unsigned DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned FW     = FRAC_BITS + 1;
  localparam int unsigned WGT_W  = 2 * FW;
  localparam int unsigned ACC_W  = 2 * FRAC_BITS + bur_pkg::CHAN_W;
  localparam int unsigned PW     = bur_pkg::POS_W;
  localparam int unsigned CHW    = bur_pkg::CHAN_W;

  bur_pkg::bur_state_e state_q, state_d;

  logic [bur_pkg::SRC_REG_W-1:0] src_width_q, src_height_q;
  logic [bur_pkg::DST_REG_W-1:0] dst_width_q, dst_height_q;

  logic [PW-1:0]        px_q, py_q;
  logic                 last_row_q;
  logic [XW-1:0]        ix_q;
  logic [YW-1:0]        iy_q;
  logic [FRAC_BITS-1:0] fx_q, fy_q;
  logic [1:0]           nbr_q;
  logic [WGT_W-1:0]     weight_q;
  logic [bur_pkg::PIX_W-1:0] rd_data_q;
  logic [ACC_W-1:0]     acc_q [4];
  logic                 out_valid_q;
  bur_pkg::bur_out_t    out_q;

  logic [bur_pkg::PIX_W-1:0] mem [DEPTH];

  logic [MW-1:0] wm1, hm1;
  logic [PW-1:0] wdm1, hdm1;

  logic              in_fire, wr_fire, req_fire, wr_in_range;
  logic              div_start, div_busy;
  logic [PW-1:0]     mul_a;
  logic [MW-1:0]     mul_b;
  logic [DEN_W-1:0]  div_den;
  logic [NUM_W-1:0]  div_num;
  logic [QW-1:0]     div_quo;
  logic              nbr_act;
  logic              mem_we, mem_re, out_load;
  logic [AW-1:0]     mem_addr, wr_addr, rd_addr;
  logic [XW-1:0]     rd_x;
  logic [YW-1:0]     rd_y;
  logic [FW-1:0]     one_fix, wx, wy;

  assign cfg_ready_o = 1'b1;

  // register values saturated to their legal ranges, minus one
  always_comb begin
    logic [15:0] sw, sh, dw, dh;
    sw = 16'(src_width_q);
    sh = 16'(src_height_q);
    dw = 16'(dst_width_q);
    dh = 16'(dst_height_q);
    if (sw < 16'd2) begin
      wm1 = MW'(1);
    end else if (sw > 16'(MAX_SRC_WIDTH)) begin
      wm1 = MW'(MAX_SRC_WIDTH - 1);
    end else begin
      wm1 = MW'(sw - 16'd1);
    end
    if (sh < 16'd2) begin
      hm1 = MW'(1);
    end else if (sh > 16'(MAX_SRC_HEIGHT)) begin
      hm1 = MW'(MAX_SRC_HEIGHT - 1);
    end else begin
      hm1 = MW'(sh - 16'd1);
    end
    if (dw < 16'd2) begin
      wdm1 = PW'(1);
    end else if (dw > 16'(bur_pkg::DST_MAX)) begin
      wdm1 = PW'(bur_pkg::DST_MAX - 1);
    end else begin
      wdm1 = PW'(dw - 16'd1);
    end
    if (dh < 16'd2) begin
      hdm1 = PW'(1);
    end else if (dh > 16'(bur_pkg::DST_MAX)) begin
      hdm1 = PW'(bur_pkg::DST_MAX - 1);
    end else begin
      hdm1 = PW'(dh - 16'd1);
    end
  end

  assign in_fire     = in_valid_i && in_ready_o;
  assign wr_fire     = in_fire && (in_data_i.func == bur_pkg::FUNC_WRITE);
  assign req_fire    = in_fire && (in_data_i.func == bur_pkg::FUNC_REQUEST);
  assign wr_in_range = (32'(in_data_i.pos_x) < MAX_SRC_WIDTH) &&
                       (32'(in_data_i.pos_y) < MAX_SRC_HEIGHT);

  // tl, tr, bl, br; a neighbour with zero weight is skipped
  assign nbr_act = (!nbr_q[0] || (fx_q != '0)) && (!nbr_q[1] || (fy_q != '0));

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      bur_pkg::ST_IDLE: begin
        if (req_fire) begin
          state_d = bur_pkg::ST_MUL_X;
        end
      end
      bur_pkg::ST_MUL_X: state_d = bur_pkg::ST_DIV_X;
      bur_pkg::ST_DIV_X: begin
        if (!div_busy) begin
          state_d = last_row_q ? bur_pkg::ST_RD : bur_pkg::ST_MUL_Y;
        end
      end
      bur_pkg::ST_MUL_Y: state_d = bur_pkg::ST_DIV_Y;
      bur_pkg::ST_DIV_Y: begin
        if (!div_busy) begin
          state_d = bur_pkg::ST_RD;
        end
      end
      bur_pkg::ST_RD: begin
        if (nbr_act) begin
          state_d = bur_pkg::ST_MAC;
        end else if (nbr_q == 2'd3) begin
          state_d = bur_pkg::ST_DONE;
        end
      end
      bur_pkg::ST_MAC: begin
        state_d = (nbr_q == 2'd3) ? bur_pkg::ST_DONE : bur_pkg::ST_RD;
      end
      bur_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = bur_pkg::ST_IDLE;
        end
      end
      default: state_d = bur_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      bur_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        mem_we     = wr_fire && wr_in_range;
      end
      bur_pkg::ST_MUL_X, bur_pkg::ST_MUL_Y: div_start = 1'b1;
      bur_pkg::ST_RD:   mem_re = nbr_act;
      bur_pkg::ST_DONE: out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bur_pkg::ST_IDLE;
      out_valid_q  <= 1'b0;
      nbr_q        <= '0;
      src_width_q  <= bur_pkg::SRC_WIDTH_RST;
      src_height_q <= bur_pkg::SRC_HEIGHT_RST;
      dst_width_q  <= bur_pkg::DST_WIDTH_RST;
      dst_height_q <= bur_pkg::DST_HEIGHT_RST;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == bur_pkg::ST_MUL_X) begin
        nbr_q <= '0;
      end else if ((state_q == bur_pkg::ST_MAC) ||
                   ((state_q == bur_pkg::ST_RD) && !nbr_act)) begin
        nbr_q <= nbr_q + 2'd1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (bur_pkg::cfg_reg_e'(cfg_index_i))
          bur_pkg::CFG_SRC_WIDTH:  src_width_q  <= cfg_data_i[bur_pkg::SRC_REG_W-1:0];
          bur_pkg::CFG_SRC_HEIGHT: src_height_q <= cfg_data_i[bur_pkg::SRC_REG_W-1:0];
          bur_pkg::CFG_DST_WIDTH:  dst_width_q  <= cfg_data_i;
          bur_pkg::CFG_DST_HEIGHT: dst_height_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // ---------------- coordinate mapping ----------------
  assign mul_a   = (state_q == bur_pkg::ST_MUL_Y) ? py_q : px_q;
  assign mul_b   = (state_q == bur_pkg::ST_MUL_Y) ? hm1 : wm1;
  assign div_den = (state_q == bur_pkg::ST_MUL_Y) ? hdm1 : wdm1;
  // full-width product, then the fraction bits below it
  assign div_num = {(PW+MW)'(mul_a) * (PW+MW)'(mul_b), {FRAC_BITS{1'b0}}};

  bur_div #(
    .DEN_W (DEN_W),
    .QUO_W (QW)
  ) u_bur_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  // ---------------- frame store ----------------
  assign rd_x     = ix_q + XW'(nbr_q[0]);
  assign rd_y     = iy_q + YW'(nbr_q[1]);
  assign rd_addr  = AW'(rd_y) * AW'(MAX_SRC_WIDTH) + AW'(rd_x);
  assign wr_addr  = AW'(in_data_i.pos_y[YW-1:0]) * AW'(MAX_SRC_WIDTH) +
                    AW'(in_data_i.pos_x[XW-1:0]);
  assign mem_addr = mem_we ? wr_addr : rd_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= {in_data_i.in_alpha, in_data_i.in_blue,
                        in_data_i.in_green, in_data_i.in_red};
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_addr];
    end
  end

  // ---------------- blend ----------------
  assign one_fix = {1'b1, {FRAC_BITS{1'b0}}};
  assign wx = nbr_q[0] ? {1'b0, fx_q} : one_fix - {1'b0, fx_q};
  assign wy = nbr_q[1] ? {1'b0, fy_q} : one_fix - {1'b0, fy_q};

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      px_q       <= (in_data_i.pos_x > wdm1) ? wdm1 : in_data_i.pos_x;
      py_q       <= in_data_i.pos_y;
      last_row_q <= in_data_i.pos_y >= hdm1;
    end
    if (state_q == bur_pkg::ST_MUL_X) begin
      for (int c = 0; c < 4; c++) begin
        acc_q[c] <= '0;
      end
    end
    if ((state_q == bur_pkg::ST_DIV_X) && !div_busy) begin
      ix_q <= div_quo[FRAC_BITS +: XW];
      fx_q <= div_quo[FRAC_BITS-1:0];
      if (last_row_q) begin
        iy_q <= hm1[YW-1:0];
        fy_q <= '0;
      end
    end
    if ((state_q == bur_pkg::ST_DIV_Y) && !div_busy) begin
      iy_q <= div_quo[FRAC_BITS +: YW];
      fy_q <= div_quo[FRAC_BITS-1:0];
    end
    if (state_q == bur_pkg::ST_RD) begin
      weight_q <= wx * wy;
    end
    if (state_q == bur_pkg::ST_MAC) begin
      for (int c = 0; c < 4; c++) begin
        acc_q[c] <= acc_q[c] + ACC_W'(weight_q) * ACC_W'(rd_data_q[c*CHW +: CHW]);
      end
    end
    if (out_load) begin
      out_q.out_red   <= acc_q[0][ACC_W-1 -: CHW];
      out_q.out_green <= acc_q[1][ACC_W-1 -: CHW];
      out_q.out_blue  <= acc_q[2][ACC_W-1 -: CHW];
      out_q.out_alpha <= acc_q[3][ACC_W-1 -: CHW];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/bur_checker.sv =====
// Port-level assertions for the bilinear upscaler, bound to the top level.
module bur_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input bur_pkg::bur_in_t               in_data_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input bur_pkg::bur_out_t              out_data_o
);

  logic wr_xfer, req_xfer;

  assign wr_xfer  = in_valid_i && in_ready_o && (in_data_i.func == bur_pkg::FUNC_WRITE);
  assign req_xfer = in_valid_i && in_ready_o && (in_data_i.func == bur_pkg::FUNC_REQUEST);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // the block is ready again after a write, and a write never yields a result
  a_wr_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_xfer |=> in_ready_o && !$rose(out_valid_o))
    else $error("write transfer did not complete in one cycle");

  // a request occupies the block
  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer |=> !in_ready_o ##1 !in_ready_o)
    else $error("input ready during a request");

  // a result appears only after a request has been taken
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_ready_o || $past(!in_ready_o))
    else $error("result without a pending request");

endmodule

bind bilinear_upscale_rgba_top bur_checker u_bur_checker (.*);

// ===== tb/sv/upscale_checker.sv =====
// Checker for the bilinear RGBA upscaler: tracks the frame store, predicts each pixel, compares.
module upscale_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  bur_pkg::bur_in_t               in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  bur_pkg::bur_out_t              out_data_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [bur_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bur_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                    mismatch_count_o,
  output int unsigned                    pending_count_o
);
  import bur_pkg::*;

  localparam int unsigned MAX_W = DEF_MAX_SRC_WIDTH;
  localparam int unsigned MAX_H = DEF_MAX_SRC_HEIGHT;
  localparam int unsigned FRAC  = DEF_FRAC_BITS;
  localparam longint unsigned ONE = 64'd1 << FRAC;

  logic [SRC_REG_W-1:0] src_width_q;
  logic [SRC_REG_W-1:0] src_height_q;
  logic [DST_REG_W-1:0] dst_width_q;
  logic [DST_REG_W-1:0] dst_height_q;

  // entry (x, y) at y * MAX_W + x, red in the low byte
  logic [PIX_W-1:0] pixel_store [MAX_W*MAX_H];
  bur_out_t         expected_pixels [$];

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bur_out_t interpolate(bur_in_t req);
    int unsigned       w, h, wd, hd, px, py, ix, iy;
    longint unsigned   sx, sy, fx, fy, upper, lower, acc;
    logic [PIX_W-1:0]  tl, tr, bl, br;
    logic [CHAN_W-1:0] blended [4];
    bur_out_t          res;
    w  = clamp_size(src_width_q, MAX_W);
    h  = clamp_size(src_height_q, MAX_H);
    wd = clamp_size(dst_width_q, DST_MAX);
    hd = clamp_size(dst_height_q, DST_MAX);
    px = req.pos_x;
    py = req.pos_y;
    if (px > wd - 1) px = wd - 1;
    sx = px;
    sx = (sx * (w - 1)) << FRAC;
    sx = sx / (wd - 1);
    ix = 32'(sx >> FRAC);
    fx = sx & (ONE - 1);
    // last destination row and below: last source row only
    if (py >= hd - 1) begin
      iy = h - 1;
      fy = 0;
    end else begin
      sy = py;
      sy = (sy * (h - 1)) << FRAC;
      sy = sy / (hd - 1);
      iy = 32'(sy >> FRAC);
      fy = sy & (ONE - 1);
    end
    // neighbours with zero weight are never fetched
    tl = pixel_store[iy*MAX_W + ix];
    tr = (fx != 0) ? pixel_store[iy*MAX_W + ix + 1] : '0;
    bl = (fy != 0) ? pixel_store[(iy+1)*MAX_W + ix] : '0;
    br = (fx != 0 && fy != 0) ? pixel_store[(iy+1)*MAX_W + ix + 1] : '0;
    for (int c = 0; c < 4; c++) begin
      upper = (ONE - fx) * tl[CHAN_W*c +: CHAN_W] + fx * tr[CHAN_W*c +: CHAN_W];
      lower = (ONE - fx) * bl[CHAN_W*c +: CHAN_W] + fx * br[CHAN_W*c +: CHAN_W];
      acc   = (ONE - fy) * upper + fy * lower;
      blended[c] = CHAN_W'(acc >> (2 * FRAC));
    end
    res.out_red   = blended[0];
    res.out_green = blended[1];
    res.out_blue  = blended[2];
    res.out_alpha = blended[3];
    return res;
  endfunction

  task automatic check_channel(string name, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    bur_out_t want;
    if (!rst_ni) begin
      src_width_q  = SRC_WIDTH_RST;
      src_height_q = SRC_HEIGHT_RST;
      dst_width_q  = DST_WIDTH_RST;
      dst_height_q = DST_HEIGHT_RST;
      expected_pixels.delete();
      mismatch_count_o = 0;
      pending_count_o  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_SRC_WIDTH:  src_width_q  = cfg_data_i[SRC_REG_W-1:0];
          CFG_SRC_HEIGHT: src_height_q = cfg_data_i[SRC_REG_W-1:0];
          CFG_DST_WIDTH:  dst_width_q  = cfg_data_i[DST_REG_W-1:0];
          CFG_DST_HEIGHT: dst_height_q = cfg_data_i[DST_REG_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          $error("result transfer with no request outstanding");
          mismatch_count_o++;
        end else begin
          want = expected_pixels.pop_front();
          check_channel("out_red", want.out_red, out_data_i.out_red);
          check_channel("out_green", want.out_green, out_data_i.out_green);
          check_channel("out_blue", want.out_blue, out_data_i.out_blue);
          check_channel("out_alpha", want.out_alpha, out_data_i.out_alpha);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.func == FUNC_REQUEST) begin
          expected_pixels.push_back(interpolate(in_data_i));
        end else if (in_data_i.pos_x < MAX_W && in_data_i.pos_y < MAX_H) begin
          pixel_store[in_data_i.pos_y*MAX_W + in_data_i.pos_x] =
            {in_data_i.in_alpha, in_data_i.in_blue, in_data_i.in_green, in_data_i.in_red};
        end
      end
      pending_count_o = expected_pixels.size();
    end
  end

endmodule

// ===== tb/sv/tb_bilinear_upscale_rgba_top.sv =====
// Testbench top for the bilinear RGBA upscaler: stimulus, receiver, watchdog and verdict.
module tb_bilinear_upscale_rgba_top;
  import bur_pkg::*;

  localparam int unsigned MAX_W         = DEF_MAX_SRC_WIDTH;
  localparam int unsigned MAX_H         = DEF_MAX_SRC_HEIGHT;
  localparam int unsigned MAX_GAP       = 7;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned STALL_LIMIT   = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  bur_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  bur_out_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned idle_cycles = 0;
  bit          hold_request;
  bit          sender_calm;
  bit          filled [MAX_H][MAX_W];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bilinear_upscale_rgba_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  upscale_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending)
  );

  // any cycle without a transfer on any channel counts toward the stall limit
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned pick_coord(int unsigned span);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom_range(0, 4095);
    if (sel == 1) return span - 1;
    return $urandom_range(0, span - 1);
  endfunction

  // valid stays up after a transfer until the next falling edge decides
  task automatic send_item(bur_in_t item);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) sender_calm = !sender_calm;
    gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_write(int unsigned x, int unsigned y, logic [PIX_W-1:0] pixel);
    bur_in_t item;
    item.func  = FUNC_WRITE;
    item.pos_x = POS_W'(x);
    item.pos_y = POS_W'(y);
    {item.in_alpha, item.in_blue, item.in_green, item.in_red} = pixel;
    if (x < MAX_W && y < MAX_H) filled[y][x] = 1'b1;
    send_item(item);
  endtask

  task automatic send_request(int unsigned x, int unsigned y);
    bur_in_t item;
    item       = bur_in_t'({$urandom, $urandom});
    item.func  = FUNC_REQUEST;
    item.pos_x = POS_W'(x);
    item.pos_y = POS_W'(y);
    send_item(item);
  endtask

  task automatic cfg_write(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drop valid, wait for every outstanding pixel, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] sw, logic [CFG_DATA_W-1:0] sh,
                           logic [CFG_DATA_W-1:0] dw, logic [CFG_DATA_W-1:0] dh,
                           int unsigned n_items, bit with_hold);
    int unsigned w, h, wd, hd, sel, done_items;
    cfg_write(CFG_SRC_WIDTH, sw);
    cfg_write(CFG_SRC_HEIGHT, sh);
    cfg_write(CFG_DST_WIDTH, dw);
    cfg_write(CFG_DST_HEIGHT, dh);
    w  = clamp_size(sw[SRC_REG_W-1:0], MAX_W);
    h  = clamp_size(sh[SRC_REG_W-1:0], MAX_H);
    wd = clamp_size(dw[DST_REG_W-1:0], DST_MAX);
    hd = clamp_size(dh[DST_REG_W-1:0], DST_MAX);
    // every pixel a request can touch must hold data first
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        if (!filled[y][x]) send_write(x, y, $urandom);
      end
    end
    if (with_hold) hold_request = 1'b1;
    done_items = 0;
    while (done_items < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        send_request(pick_coord(wd), pick_coord(hd));
      end else if (sel < 90) begin
        send_write($urandom_range(0, w - 1), $urandom_range(0, h - 1), $urandom);
      end else if (sel < 95) begin
        send_write($urandom_range(MAX_W, 4095), $urandom_range(0, 4095), $urandom);
      end else begin
        send_write($urandom_range(0, 4095), $urandom_range(MAX_H, 4095), $urandom);
      end
      done_items++;
    end
    settle();
  endtask

  initial begin : receiver
    int unsigned gap;
    bit          calm;
    out_ready = 1'b0;
    calm      = 1'b0;
    forever begin
      if ($urandom_range(0, 31) == 0) calm = !calm;
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (hold_request) begin
        gap          = LONG_HOLD;
        hold_request = 1'b0;
      end
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    logic [PIX_W-1:0] pattern;
    int unsigned      probe_x [10];
    int unsigned      probe_y [10];
    logic [CFG_DATA_W-1:0] dw;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    hold_request = 1'b0;
    sender_calm  = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: 4x3 source onto 7x5, extremes of every channel
    cfg_write(CFG_SRC_WIDTH, 4);
    cfg_write(CFG_SRC_HEIGHT, 3);
    cfg_write(CFG_DST_WIDTH, 7);
    cfg_write(CFG_DST_HEIGHT, 5);
    pattern = 32'h5AA500FF;
    for (int y = 0; y < 3; y++) begin
      for (int x = 0; x < 4; x++) begin
        send_write(x, y, PIX_W'({pattern, pattern} >> (8 * ((x + y) % 4))));
      end
    end
    // writes outside the store are dropped
    send_write(MAX_W, 0, '1);
    send_write(0, MAX_H, '1);
    send_write(4095, 4095, '1);
    // corners, last row, saturated positions, zero-weight and full four-way blends
    probe_x = '{0, 1, 6, 3, 4095, 4095, 0, 2, 1, 5};
    probe_y = '{0, 1, 4, 4, 4095, 0, 4095, 2, 2, 1};
    for (int i = 0; i < 10; i++) send_request(probe_x[i], probe_y[i]);
    settle();

    run_phase(2, 2, 2, 2, 25, 1'b0);
    run_phase(128, 2, 4096, 300, 30, 1'b0);
    run_phase(2, 24, 3, 4096, 30, 1'b0);
    // register values outside the legal range, high bits set
    run_phase(13'h00FF, 13'h1F00, 13'h1FFF, 0, 25, 1'b0);
    run_phase(1, 1, 1, 1, 20, 1'b0);

    for (int k = 0; k < 6; k++) begin
      dw = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(2, 4096))
                                       : CFG_DATA_W'($urandom_range(2, 40));
      run_phase(CFG_DATA_W'($urandom_range(2, 8)), CFG_DATA_W'($urandom_range(2, 8)), dw,
                ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(2, 4096))
                                            : CFG_DATA_W'($urandom_range(2, 40)),
                15, k == 1);
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
